// ===== src/link_frame_header_recognizer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// link frame header recognizer - assertion macros
// concurrent assertion wrappers used by the checker file
// ----------------------------------------------------------------------------
`ifndef LINK_FRAME_HEADER_RECOGNIZER_UNIT_DEFINES_SVH
`define LINK_FRAME_HEADER_RECOGNIZER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LFHR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LFHR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define LFHR_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lfhr_pkg.sv =====
// ----------------------------------------------------------------------------
// lfhr_pkg
// types, register indexes and state codes of the frame header recognizer
// ----------------------------------------------------------------------------
`default_nettype none

package lfhr_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] parse_state;
    logic       frame_done;
  } out_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] flag_byte;
    logic [7:0] answer_address;
    logic [7:0] command_address;
    logic [7:0] control_primary;
    logic [7:0] control_reject;
    logic [7:0] disconnect_control;
  } cfg_t;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [CfgIndexW-1:0] REG_MODE         = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_FLAG_BYTE    = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_ANSWER_ADDR  = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_COMMAND_ADDR = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_CTRL_PRIMARY = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_CTRL_REJECT  = 3'd5;
  localparam logic [CfgIndexW-1:0] REG_DISC_CTRL    = 3'd6;

  localparam logic [1:0] MODE_ESTABLISH = 2'd0;
  localparam logic [1:0] MODE_SENDER    = 2'd1;
  localparam logic [1:0] MODE_RECEIVER  = 2'd2;
  localparam logic [1:0] MODE_TERMINATE = 2'd3;

  localparam cfg_t CFG_RESET = '{
    mode:               MODE_ESTABLISH,
    flag_byte:          8'd126,
    answer_address:     8'd3,
    command_address:    8'd1,
    control_primary:    8'd0,
    control_reject:     8'd0,
    disconnect_control: 8'd11
  };

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  localparam logic [3:0] CODE_START = 4'd0;
  localparam logic [3:0] CODE_FLAG  = 4'd1;
  localparam logic [3:0] CODE_ADDR  = 4'd2;
  localparam logic [3:0] CODE_CTRL  = 4'd3;
  localparam logic [3:0] CODE_RR    = 4'd4;
  localparam logic [3:0] CODE_REJ   = 4'd5;
  localparam logic [3:0] CODE_INFO  = 4'd6;
  localparam logic [3:0] CODE_CHECK = 4'd7;
  localparam logic [3:0] CODE_DATA  = 4'd8;
  localparam logic [3:0] CODE_STOP  = 4'd9;

  typedef enum logic [9:0] {
    S_START = 10'b00_0000_0001,
    S_FLAG  = 10'b00_0000_0010,
    S_ADDR  = 10'b00_0000_0100,
    S_CTRL  = 10'b00_0000_1000,
    S_RR    = 10'b00_0001_0000,
    S_REJ   = 10'b00_0010_0000,
    S_INFO  = 10'b00_0100_0000,
    S_CHECK = 10'b00_1000_0000,
    S_DATA  = 10'b01_0000_0000,
    S_STOP  = 10'b10_0000_0000
  } state_t;

  function automatic logic [3:0] state_code(input state_t s);
    logic [3:0] code;
    case (s)
      S_START: code = CODE_START;
      S_FLAG:  code = CODE_FLAG;
      S_ADDR:  code = CODE_ADDR;
      S_CTRL:  code = CODE_CTRL;
      S_RR:    code = CODE_RR;
      S_REJ:   code = CODE_REJ;
      S_INFO:  code = CODE_INFO;
      S_CHECK: code = CODE_CHECK;
      S_DATA:  code = CODE_DATA;
      S_STOP:  code = CODE_STOP;
      default: code = CODE_START;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== src/lfhr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lfhr_cfg_regs
// configuration register file written through the plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module lfhr_cfg_regs
  import lfhr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:         cfg.mode               <= cfg_data[1:0];
        REG_FLAG_BYTE:    cfg.flag_byte          <= cfg_data;
        REG_ANSWER_ADDR:  cfg.answer_address     <= cfg_data;
        REG_COMMAND_ADDR: cfg.command_address    <= cfg_data;
        REG_CTRL_PRIMARY: cfg.control_primary    <= cfg_data;
        REG_CTRL_REJECT:  cfg.control_reject     <= cfg_data;
        REG_DISC_CTRL:    cfg.disconnect_control <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/lfhr_next_state.sv =====
// ----------------------------------------------------------------------------
// lfhr_next_state
// next-state function of the header recognizer for one received item
// ----------------------------------------------------------------------------
`default_nettype none

module lfhr_next_state
  import lfhr_pkg::*;
(
  input  wire cfg_t     cfg,
  input  wire state_t   state,
  input  wire in_item_t item,
  output state_t        state_next
);

  logic [7:0] addr;
  logic [7:0] b;
  state_t     miss;

  always_comb begin
    b    = item.rx_byte;
    addr = (cfg.mode == MODE_TERMINATE) ? cfg.command_address : cfg.answer_address;
    miss = (b == cfg.flag_byte) ? S_FLAG : S_START;
    state_next = state;
    if (item.kind == KIND_RESTART) begin
      state_next = S_START;
    end else begin
      case (state)
        S_START: state_next = miss;
        S_FLAG:  state_next = (b == addr) ? S_ADDR : miss;
        S_ADDR: begin
          if (cfg.mode == MODE_SENDER) begin
            if (b == cfg.control_primary)     state_next = S_RR;
            else if (b == cfg.control_reject) state_next = S_REJ;
            else                              state_next = miss;
          end else if (cfg.mode == MODE_RECEIVER) begin
            if (b == cfg.disconnect_control)   state_next = S_CTRL;
            else if (b == cfg.control_primary) state_next = S_INFO;
            else                               state_next = miss;
          end else begin
            state_next = (b == cfg.control_primary) ? S_CTRL : miss;
          end
        end
        S_CTRL: begin
          if (cfg.mode == MODE_SENDER) begin
            state_next = state;
          end else if (cfg.mode == MODE_RECEIVER) begin
            state_next = (b == (cfg.answer_address ^ cfg.disconnect_control)) ?
                         S_CHECK : miss;
          end else begin
            state_next = (b == (addr ^ cfg.control_primary)) ? S_CHECK : miss;
          end
        end
        S_RR: begin
          if (cfg.mode == MODE_SENDER)
            state_next = (b == (cfg.answer_address ^ cfg.control_primary)) ?
                         S_CHECK : miss;
        end
        S_REJ: begin
          if (cfg.mode == MODE_SENDER)
            state_next = (b == (cfg.answer_address ^ cfg.control_reject)) ?
                         S_CHECK : miss;
        end
        S_INFO: begin
          if (cfg.mode == MODE_RECEIVER)
            state_next = (b == (cfg.answer_address ^ cfg.control_primary)) ?
                         S_DATA : miss;
        end
        S_DATA: begin
          // payload skipped until the closing flag
          if (cfg.mode == MODE_RECEIVER)
            state_next = (b == cfg.flag_byte) ? S_STOP : S_DATA;
        end
        S_CHECK: state_next = (b == cfg.flag_byte) ? S_STOP : S_START;
        S_STOP:  state_next = S_STOP;
        default: state_next = state;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/link_frame_header_recognizer_unit.sv =====
// ----------------------------------------------------------------------------
// link_frame_header_recognizer_unit
// recognizes flag, address, control, header check, optional payload, flag over a byte stream
// ----------------------------------------------------------------------------
// One result per transfer, one transfer per clock sustained while the output
// is not stalled. A transfer is captured into an input register; the
// next-state function between that register and the result register updates
// the recogniser state, and the result is registered in the result register.
// The loop through the state register and the next-state function sets the
// rate. Output back-pressure stalls both stages; an empty input stage still
// takes a transfer while a result waits. Configuration writes apply at once.
// ----------------------------------------------------------------------------
`default_nettype none

module link_frame_header_recognizer_unit
  import lfhr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_item
);

  cfg_t     cfg;
  logic     stage_valid;
  in_item_t stage_item;
  state_t   state;
  state_t   state_next;
  logic     advance;

  lfhr_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfhr_next_state u_next_state (
    .cfg        (cfg),
    .state      (state),
    .item       (stage_item),
    .state_next (state_next)
  );

  assign advance  = !out_valid || out_ready;
  assign in_ready = !stage_valid || advance;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_item <= in_item;
    end
  end

  // state and result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_START;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
      if (stage_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      out_item.parse_state <= state_code(state_next);
      out_item.frame_done  <= (state_next == S_STOP);
    end
  end

endmodule

`default_nettype wire

// ===== src/lfhr_checker.sv =====
// ----------------------------------------------------------------------------
// lfhr_checker
// port-level checks of the frame header recognizer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "link_frame_header_recognizer_unit_defines.svh"

module lfhr_checker
  import lfhr_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  logic done_agrees;
  logic out_stalled;

  assign done_agrees = out_item.frame_done == (out_item.parse_state == CODE_STOP);
  assign out_stalled = out_valid && !out_ready;

  `LFHR_ASSERT_ALWAYS(a_reset_empty, rst, !out_valid, "result valid after reset")
  `LFHR_ASSERT_SAME(a_done_match, out_valid, done_agrees, "frame_done disagrees with state")
  `LFHR_ASSERT_SAME(a_state_range, out_valid, out_item.parse_state <= CODE_STOP, "bad state code")
  `LFHR_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")
  `LFHR_ASSERT_NEXT(a_result_held, out_stalled, out_valid && $stable(out_item), "held result changed")

endmodule

bind link_frame_header_recognizer_unit lfhr_checker u_lfhr_checker (.*);

`default_nettype wire
